// ===== rtl/core/faes_pkg.sv =====
// Shared types, constants and the log mantissa table for the frame statistics block.
`timescale 1ns / 1ps
`default_nettype none
package faes_pkg;

  // Frame geometry and field widths.
  localparam int MAX_CLASSES = 64;
  localparam int CLS_W       = $clog2(MAX_CLASSES);
  localparam int NCLS_W      = CLS_W + 1;
  localparam int P_W         = 16;
  localparam int LABEL_W     = 8;

  // Fixed-point widths of the entropy path.
  localparam int NL_W   = 20;
  localparam int PROD_W = P_W + NL_W + 1;
  localparam int TERM_W = PROD_W - 16;
  localparam int ACC_W  = 32;
  localparam int ENT_W  = 20;
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 48;

  // Log table geometry; the depth is a power of two.
  localparam int LOG_DEPTH = 256;
  localparam int LOG_IDX_W = $clog2(LOG_DEPTH);
  localparam logic [P_W-1:0] LN2_Q16 = 16'd45426;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = NCLS_W;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CLASSES    = 1'b0,
    CFG_ENTROPY_ENABLE = 1'b1
  } cfg_idx_t;

  // Frame update handed to the statistics unit.
  typedef struct packed {
    logic             valid;
    logic             correct;
    logic             enable;
    logic [ENT_W-1:0] ent;
  } faes_upd_t;

  typedef logic [LOG_DEPTH-1:0][15:0] log_tab_t;

  // Shift-and-subtract division used only while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k holds ln(1 + k/LOG_DEPTH) in Q16, evaluated as 2*atanh(k/(2*LOG_DEPTH+k)) in Q30.
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] rnd;
    for (int k = 0; k < LOG_DEPTH; k++) begin
      y    = udiv64(64'(k) << 30, 64'(2 * LOG_DEPTH + k));
      y2   = (y * y) >> 30;
      term = y;
      acc  = '0;
      for (int n = 0; n < 24; n++) begin
        acc  = acc + udiv64(term, 64'(2 * n + 1));
        term = (term * y2) >> 30;
      end
      rnd  = ((acc << 1) + 64'd8192) >> 14;
      t[k] = rnd[15:0];
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage
`default_nettype wire

// ===== rtl/core/faes_neglog.sv =====
// Negative natural log of a Q0.16 probability in Q4.16, from a leading-one search and table.
`timescale 1ns / 1ps
`default_nettype none
module faes_neglog (
  input  wire logic [faes_pkg::P_W-1:0]  prob,
  output logic      [faes_pkg::NL_W-1:0] neg_log
);

  logic [3:0]                       lead;
  logic [faes_pkg::P_W-1:0]         norm;
  logic [faes_pkg::LOG_IDX_W-1:0]   tab_idx;
  logic [15:0]                      tab_val;
  logic [4:0]                       octave;
  logic [faes_pkg::NL_W-1:0]        base;
  logic [faes_pkg::NL_W-1:0]        tab_ext;

  // Position of the leading one.
  always_comb begin
    lead = '0;
    for (int i = 0; i < faes_pkg::P_W; i++) begin
      if (prob[i]) begin
        lead = 4'(i);
      end
    end
  end

  // Normalize, then the top fraction bits address the mantissa table.
  assign norm    = prob << (4'd15 - lead);
  assign tab_idx = norm[14 -: faes_pkg::LOG_IDX_W];
  assign tab_val = faes_pkg::LOG_TAB[tab_idx];

  // Octave part minus mantissa part, floored at zero; a zero probability gives zero.
  assign octave  = 5'd16 - {1'b0, lead};
  assign base    = faes_pkg::NL_W'(octave) * faes_pkg::NL_W'(faes_pkg::LN2_Q16);
  assign tab_ext = faes_pkg::NL_W'(tab_val);
  assign neg_log = ((prob != '0) && (base > tab_ext)) ? (base - tab_ext) : '0;

endmodule
`default_nettype wire

// ===== rtl/core/faes_stats.sv =====
// Saturating frame counts, entropy sums and entropy min/max per frame outcome.
`timescale 1ns / 1ps
`default_nettype none
module faes_stats (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire faes_pkg::faes_upd_t        upd,
  output logic [faes_pkg::CNT_W-1:0]      correct_count,
  output logic [faes_pkg::CNT_W-1:0]      false_count,
  output logic [faes_pkg::SUM_W-1:0]      correct_sum,
  output logic [faes_pkg::SUM_W-1:0]      false_sum,
  output logic [faes_pkg::ENT_W-1:0]      correct_min,
  output logic [faes_pkg::ENT_W-1:0]      correct_max,
  output logic [faes_pkg::ENT_W-1:0]      false_min,
  output logic [faes_pkg::ENT_W-1:0]      false_max
);

  logic [faes_pkg::CNT_W-1:0] cnt_c_r, cnt_c_nxt, cnt_f_r, cnt_f_nxt;
  logic [faes_pkg::SUM_W-1:0] sum_c_r, sum_c_nxt, sum_f_r, sum_f_nxt;
  logic [faes_pkg::ENT_W-1:0] min_c_r, min_c_nxt, max_c_r, max_c_nxt;
  logic [faes_pkg::ENT_W-1:0] min_f_r, min_f_nxt, max_f_r, max_f_nxt;
  logic [faes_pkg::SUM_W:0]   sum_add;
  logic [faes_pkg::SUM_W-1:0] sum_sel;
  logic [faes_pkg::SUM_W-1:0] sum_sat;

  // One shared saturating adder serves whichever outcome the frame has.
  assign sum_sel = upd.correct ? sum_c_r : sum_f_r;
  assign sum_add = {1'b0, sum_sel} + (faes_pkg::SUM_W + 1)'(upd.ent);
  assign sum_sat = sum_add[faes_pkg::SUM_W] ? '1 : sum_add[faes_pkg::SUM_W-1:0];

  // Next values of the statistics.
  always_comb begin
    cnt_c_nxt = cnt_c_r;
    cnt_f_nxt = cnt_f_r;
    sum_c_nxt = sum_c_r;
    sum_f_nxt = sum_f_r;
    min_c_nxt = min_c_r;
    max_c_nxt = max_c_r;
    min_f_nxt = min_f_r;
    max_f_nxt = max_f_r;
    if (upd.valid) begin
      if (upd.correct) begin
        if (cnt_c_r != '1) begin
          cnt_c_nxt = cnt_c_r + 1'b1;
        end
        if (upd.enable) begin
          sum_c_nxt = sum_sat;
          min_c_nxt = (upd.ent < min_c_r) ? upd.ent : min_c_r;
          max_c_nxt = (upd.ent > max_c_r) ? upd.ent : max_c_r;
        end
      end else begin
        if (cnt_f_r != '1) begin
          cnt_f_nxt = cnt_f_r + 1'b1;
        end
        if (upd.enable) begin
          sum_f_nxt = sum_sat;
          min_f_nxt = (upd.ent < min_f_r) ? upd.ent : min_f_r;
          max_f_nxt = (upd.ent > max_f_r) ? upd.ent : max_f_r;
        end
      end
    end
  end

  // Statistics registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_c_r <= '0;
      cnt_f_r <= '0;
      sum_c_r <= '0;
      sum_f_r <= '0;
      min_c_r <= '1;
      max_c_r <= '0;
      min_f_r <= '1;
      max_f_r <= '0;
    end else begin
      cnt_c_r <= cnt_c_nxt;
      cnt_f_r <= cnt_f_nxt;
      sum_c_r <= sum_c_nxt;
      sum_f_r <= sum_f_nxt;
      min_c_r <= min_c_nxt;
      max_c_r <= max_c_nxt;
      min_f_r <= min_f_nxt;
      max_f_r <= max_f_nxt;
    end
  end

  assign correct_count = cnt_c_r;
  assign false_count   = cnt_f_r;
  assign correct_sum   = sum_c_r;
  assign false_sum     = sum_f_r;
  assign correct_min   = min_c_r;
  assign correct_max   = max_c_r;
  assign false_min     = min_f_r;
  assign false_max     = max_f_r;

endmodule
`default_nettype wire

// ===== rtl/core/frame_argmax_entropy_stats_top.sv =====
// Top level: per-frame argmax, entropy and running accuracy statistics over posterior words.
// Throughput: one probability word per cycle; a new word is taken every cycle while the
// pipeline can move, and every stage holds its word independently under backpressure.
// A frame's last accepted word passes the register, log-lookup, multiply and accumulate
// stages and then the result register, where the frame result appears.
// Reset (synchronous, rst_n low): num_classes 64, entropy disabled, counts and sums zero,
// minimums all ones, maximums zero, pipeline empty and a new frame starts.
`timescale 1ns / 1ps
`default_nettype none
module frame_argmax_entropy_stats_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Configuration write port.
  input  wire logic                                cfg_we,
  input  wire logic [faes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [faes_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // Probability words.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [faes_pkg::P_W-1:0]            in_probability,
  input  wire logic [faes_pkg::LABEL_W-1:0]        in_frame_label,
  // Frame results.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [faes_pkg::CLS_W-1:0]               out_predicted_class,
  output logic                                     out_is_correct,
  output logic                                     out_label_out_of_range,
  output logic [faes_pkg::ENT_W-1:0]               out_frame_entropy,
  output logic [faes_pkg::CNT_W-1:0]               out_correct_count,
  output logic [faes_pkg::CNT_W-1:0]               out_false_count,
  output logic [faes_pkg::SUM_W-1:0]               out_correct_entropy_sum,
  output logic [faes_pkg::SUM_W-1:0]               out_false_entropy_sum,
  output logic [faes_pkg::ENT_W-1:0]               out_correct_entropy_min,
  output logic [faes_pkg::ENT_W-1:0]               out_correct_entropy_max,
  output logic [faes_pkg::ENT_W-1:0]               out_false_entropy_min,
  output logic [faes_pkg::ENT_W-1:0]               out_false_entropy_max
);

  // Configuration registers.
  logic [faes_pkg::NCLS_W-1:0] ncls_r;
  logic                        ent_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncls_r   <= faes_pkg::NCLS_W'(faes_pkg::MAX_CLASSES);
      ent_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (faes_pkg::cfg_idx_t'(cfg_index))
        faes_pkg::CFG_NUM_CLASSES:    ncls_r   <= cfg_wdata;
        faes_pkg::CFG_ENTROPY_ENABLE: ent_en_r <= cfg_wdata[0];
        default:                      ncls_r   <= ncls_r;
      endcase
    end
  end

  // Effective class count, clamped to 1..MAX_CLASSES.
  logic [faes_pkg::NCLS_W-1:0] n_eff;
  logic [faes_pkg::NCLS_W-1:0] n_last;

  always_comb begin
    if (ncls_r == '0) begin
      n_eff = faes_pkg::NCLS_W'(1);
    end else if (ncls_r > faes_pkg::NCLS_W'(faes_pkg::MAX_CLASSES)) begin
      n_eff = faes_pkg::NCLS_W'(faes_pkg::MAX_CLASSES);
    end else begin
      n_eff = ncls_r;
    end
  end
  assign n_last = n_eff - 1'b1;

  // Stage handshake: each stage advances when the one after it is empty or moving.
  logic va_r, vb_r, vc_r, vd_r, out_valid_r;
  logic ready_o, ready_d, ready_c, ready_b, ready_a;
  logic d_go, c_go, b_go, a_go, in_go;
  logic d_last_r;

  assign ready_o  = !out_valid_r || !out_stall;
  assign d_go     = vd_r && (!d_last_r || ready_o);
  assign ready_d  = !vd_r || d_go;
  assign c_go     = vc_r && ready_d;
  assign ready_c  = !vc_r || ready_d;
  assign b_go     = vb_r && ready_c;
  assign ready_b  = !vb_r || ready_c;
  assign a_go     = va_r && ready_b;
  assign ready_a  = !va_r || ready_b;
  assign in_stall = !ready_a;
  assign in_go    = in_valid && ready_a;

  // Position of the word in its frame.
  logic [faes_pkg::CLS_W-1:0] elem_r, elem_nxt;
  logic                       in_last;
  logic                       in_oor;

  assign in_last  = {1'b0, elem_r} >= n_last;
  assign in_oor   = in_frame_label >= faes_pkg::LABEL_W'(n_eff);
  assign elem_nxt = in_last ? '0 : (elem_r + 1'b1);

  // Stage A: registered input word.
  logic [faes_pkg::P_W-1:0]     a_v_r;
  logic [faes_pkg::LABEL_W-1:0] a_label_r;
  logic [faes_pkg::CLS_W-1:0]   a_idx_r;
  logic                         a_first_r, a_last_r, a_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      elem_r <= '0;
    end else begin
      if (in_go) begin
        elem_r <= elem_nxt;
      end
      if (ready_a) begin
        va_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      a_v_r     <= in_probability;
      a_label_r <= in_frame_label;
      a_idx_r   <= elem_r;
      a_first_r <= (elem_r == '0);
      a_last_r  <= in_last;
      a_oor_r   <= in_oor;
    end
  end

  // Running argmax; the first maximum wins on ties.
  logic [faes_pkg::P_W-1:0]   best_v_r;
  logic [faes_pkg::CLS_W-1:0] best_i_r;
  logic                       take_new;
  logic [faes_pkg::CLS_W-1:0] pred_nxt;

  assign take_new = a_first_r || (a_v_r > best_v_r);
  assign pred_nxt = take_new ? a_idx_r : best_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_r <= '0;
      best_i_r <= '0;
    end else if (a_go && take_new) begin
      best_v_r <= a_v_r;
      best_i_r <= a_idx_r;
    end
  end

  // Stage B: negative log of the probability.
  logic [faes_pkg::NL_W-1:0]    nl_a;
  logic [faes_pkg::P_W-1:0]     b_v_r;
  logic [faes_pkg::NL_W-1:0]    b_nl_r;
  logic [faes_pkg::LABEL_W-1:0] b_label_r;
  logic [faes_pkg::CLS_W-1:0]   b_pred_r;
  logic                         b_first_r, b_last_r, b_oor_r;

  faes_neglog u_neglog (
    .prob    (a_v_r),
    .neg_log (nl_a)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (ready_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_v_r     <= a_v_r;
      b_nl_r    <= nl_a;
      b_label_r <= a_label_r;
      b_pred_r  <= pred_nxt;
      b_first_r <= a_first_r;
      b_last_r  <= a_last_r;
      b_oor_r   <= a_oor_r;
    end
  end

  // Stage C: entropy term p * (-ln p), rounded half up.
  logic [faes_pkg::PROD_W-1:0]  prod_b;
  logic [faes_pkg::TERM_W-1:0]  c_term_r;
  logic [faes_pkg::LABEL_W-1:0] c_label_r;
  logic [faes_pkg::CLS_W-1:0]   c_pred_r;
  logic                         c_first_r, c_last_r, c_oor_r;

  assign prod_b = faes_pkg::PROD_W'(b_v_r) * faes_pkg::PROD_W'(b_nl_r)
                + faes_pkg::PROD_W'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (ready_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      c_term_r  <= prod_b[faes_pkg::PROD_W-1:16];
      c_label_r <= b_label_r;
      c_pred_r  <= b_pred_r;
      c_first_r <= b_first_r;
      c_last_r  <= b_last_r;
      c_oor_r   <= b_oor_r;
    end
  end

  // Stage D: saturating entropy accumulation and frame verdict.
  logic [faes_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [faes_pkg::ACC_W:0]   acc_add;
  logic [faes_pkg::ACC_W-1:0] acc_base;
  logic [faes_pkg::ENT_W-1:0] ent_c;
  logic [faes_pkg::ENT_W-1:0] d_ent_r;
  logic [faes_pkg::CLS_W-1:0] d_pred_r;
  logic                       d_corr_r, d_oor_r;

  assign acc_base = c_first_r ? '0 : acc_r;
  assign acc_add  = {1'b0, acc_base} + (faes_pkg::ACC_W + 1)'(c_term_r);
  assign acc_nxt  = acc_add[faes_pkg::ACC_W] ? '1 : acc_add[faes_pkg::ACC_W-1:0];

  always_comb begin
    if (!ent_en_r) begin
      ent_c = '0;
    end else if (acc_nxt[faes_pkg::ACC_W-1:faes_pkg::ENT_W] != '0) begin
      ent_c = '1;
    end else begin
      ent_c = acc_nxt[faes_pkg::ENT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      if (ready_d) begin
        vd_r <= vc_r;
      end
      if (c_go) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_go) begin
      d_ent_r  <= ent_c;
      d_pred_r <= c_pred_r;
      d_oor_r  <= c_oor_r;
      d_corr_r <= !c_oor_r && (c_label_r == faes_pkg::LABEL_W'(c_pred_r));
      d_last_r <= c_last_r;
    end
  end

  // Statistics update as a frame's last word enters the result register, unless its label is out of range.
  faes_pkg::faes_upd_t upd;

  assign upd.valid   = d_go && d_last_r && !d_oor_r;
  assign upd.correct = d_corr_r;
  assign upd.enable  = ent_en_r;
  assign upd.ent     = d_ent_r;

  faes_stats u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd           (upd),
    .correct_count (out_correct_count),
    .false_count   (out_false_count),
    .correct_sum   (out_correct_entropy_sum),
    .false_sum     (out_false_entropy_sum),
    .correct_min   (out_correct_entropy_min),
    .correct_max   (out_correct_entropy_max),
    .false_min     (out_false_entropy_min),
    .false_max     (out_false_entropy_max)
  );

  // Result register for the per-frame fields; statistics only change when it loads.
  logic [faes_pkg::CLS_W-1:0] out_pred_r;
  logic                       out_corr_r, out_oor_r;
  logic [faes_pkg::ENT_W-1:0] out_ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_o) begin
      out_valid_r <= d_go && d_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_go && d_last_r) begin
      out_pred_r <= d_pred_r;
      out_corr_r <= d_corr_r;
      out_oor_r  <= d_oor_r;
      out_ent_r  <= d_ent_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_predicted_class    = out_pred_r;
  assign out_is_correct         = out_corr_r;
  assign out_label_out_of_range = out_oor_r;
  assign out_frame_entropy      = out_ent_r;

  // A frame is never both correct and out of range.
  a_corr_excl_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_correct && out_label_out_of_range))
    else $error("result word flags a correct frame with an out-of-range label");

  // Entropy reads zero while entropy statistics are disabled.
  a_ent_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ent_en_r |-> out_frame_entropy == '0)
    else $error("frame entropy nonzero with entropy disabled");

  // Saturating counts never go down.
  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_correct_count >= $past(out_correct_count))
                  && (out_false_count >= $past(out_false_count)))
    else $error("frame count decreased");

endmodule
`default_nettype wire
